>>> sv/tlsa_pkg.sv
package tlsa_pkg;

  // default sizes
  localparam int SUPER_SLOTS_DEF = 64;
  localparam int MAX_SUBS_DEF    = 256;

  // field widths
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 25;
  localparam int FIELD_W  = 16;                  // super field, low 16 bits of a handle
  localparam int SUBF_W   = HANDLE_W - FIELD_W;  // sub field, upper part of a handle
  localparam int CFG_W    = 9;
  localparam int STATUS_W = 2;
  localparam int DROP_W   = 6;

  localparam logic [CFG_W-1:0] ARITY_RST = 9'd64;

  // opcodes
  localparam logic [OP_W-1:0] OP_ALLOC       = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH_EMPTY = 2'd2;
  localparam logic [OP_W-1:0] OP_FLUSH_ALL   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic                opened_new;
    logic [DROP_W-1:0]   dropped_slot;
    logic                dropped_valid;
    logic                last;
  } rsp_t;

endpackage

>>> sv/tlsa_req_if.sv
interface tlsa_req_if import tlsa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [HANDLE_W-1:0] handle_in;

  modport source (output valid, output opcode, output handle_in, input ready);
  modport sink   (input valid, input opcode, input handle_in, output ready);
endinterface

>>> sv/tlsa_rsp_if.sv
interface tlsa_rsp_if import tlsa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] handle_out;
  logic                opened_new;
  logic [DROP_W-1:0]   dropped_slot;
  logic                dropped_valid;
  logic                last;

  modport source (output valid, output status, output handle_out, output opened_new,
                  output dropped_slot, output dropped_valid, output last, input ready);
  modport sink   (input valid, input status, input handle_out, input opened_new,
                  input dropped_slot, input dropped_valid, input last, output ready);
endinterface

>>> sv/tlsa_ram.sv
module tlsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tlsa_out_reg.sv
module tlsa_out_reg import tlsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rsp_t rsp_i,
  output logic can_load_o,
  tlsa_rsp_if.source rsp_o
);

  logic valid_q;
  rsp_t data_q;

  // register is free when empty or its transfer happens this cycle
  assign can_load_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.status        = data_q.status;
  assign rsp_o.handle_out    = data_q.handle_out;
  assign rsp_o.opened_new    = data_q.opened_new;
  assign rsp_o.dropped_slot  = data_q.dropped_slot;
  assign rsp_o.dropped_valid = data_q.dropped_valid;
  assign rsp_o.last          = data_q.last;

endmodule

>>> sv/tlsa_ctrl.sv
module tlsa_ctrl import tlsa_pkg::*; #(
  parameter int SUPER_SLOTS = SUPER_SLOTS_DEF,
  parameter int MAX_SUBS    = MAX_SUBS_DEF,
  localparam int SLOT_W  = (SUPER_SLOTS > 1) ? $clog2(SUPER_SLOTS) : 1,
  localparam int SUB_W   = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1,
  localparam int DEPTH_W = $clog2(MAX_SUBS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  tlsa_req_if.sink                req_i,
  input  logic [DEPTH_W-1:0]      arity_i,
  input  logic                    can_emit_i,
  output logic                    emit_o,
  output rsp_t                    rsp_o,
  // free depth store
  output logic                    dep_we_o,
  output logic [SLOT_W-1:0]       dep_waddr_o,
  output logic [DEPTH_W-1:0]      dep_wdata_o,
  output logic [SLOT_W-1:0]       dep_raddr_o,
  input  logic [DEPTH_W-1:0]      dep_rdata_i,
  // free stack store
  output logic                    stk_we_o,
  output logic [SLOT_W+SUB_W-1:0] stk_waddr_o,
  output logic [SUB_W-1:0]        stk_wdata_o,
  output logic [SLOT_W+SUB_W-1:0] stk_raddr_o,
  input  logic [SUB_W-1:0]        stk_rdata_i
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SUPER_SLOTS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_RD   = 4'd1;
  localparam logic [3:0] S_A_CK   = 4'd2;
  localparam logic [3:0] S_A_POP  = 4'd3;
  localparam logic [3:0] S_A_MISS = 4'd4;
  localparam logic [3:0] S_A_FILL = 4'd5;
  localparam logic [3:0] S_R_RD   = 4'd6;
  localparam logic [3:0] S_R_CK   = 4'd7;
  localparam logic [3:0] S_F_RD   = 4'd8;
  localparam logic [3:0] S_F_CK   = 4'd9;
  localparam logic [3:0] S_F_END  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]             state_q, state_d;
  logic [3:0]             ret_q, ret_d;
  logic [SUPER_SLOTS-1:0] present_q, present_d;
  logic                   abs_vld_q, abs_vld_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [SLOT_W-1:0]      abs_idx_q, abs_idx_d;
  logic [SLOT_W-1:0]      pend_idx_q, pend_idx_d;
  logic                   force_q, force_d;
  logic [SUBF_W-1:0]      b_q, b_d;
  logic [SUB_W-1:0]       k_q, k_d;
  rsp_t                   rsp_q, rsp_d;

  logic [FIELD_W-1:0]     super_f;
  logic [SUBF_W-1:0]      sub_f;
  logic                   rel_ok;
  logic [DEPTH_W-1:0]     dep_dec, dep_inc, arity_m1;
  logic                   fl_step, fl_drop, open_done;
  logic [3:0]             fl_next;

  // release fields and the checks that need no stored state
  assign super_f = req_i.handle_in[FIELD_W-1:0];
  assign sub_f   = req_i.handle_in[HANDLE_W-1:FIELD_W];
  assign rel_ok  = (super_f != '0) && (super_f <= FIELD_W'(SUPER_SLOTS)) && (sub_f != '0);

  // shared depth arithmetic
  assign dep_dec  = dep_rdata_i - DEPTH_W'(1);
  assign dep_inc  = dep_rdata_i + DEPTH_W'(1);
  assign arity_m1 = arity_i - DEPTH_W'(1);

  // both stores are read at the slot under the scan pointer
  assign dep_raddr_o = idx_q;
  assign stk_raddr_o = {idx_q, dep_dec[SUB_W-1:0]};

  assign fl_next = (idx_q == LAST_IDX) ? S_F_END : S_F_RD;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o       = rsp_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    present_d   = present_q;
    abs_vld_d   = abs_vld_q;
    pend_vld_d  = pend_vld_q;
    idx_d       = idx_q;
    abs_idx_d   = abs_idx_q;
    pend_idx_d  = pend_idx_q;
    force_d     = force_q;
    b_d         = b_q;
    k_d         = k_q;
    rsp_d       = rsp_q;
    emit_o      = 1'b0;
    dep_we_o    = 1'b0;
    dep_waddr_o = idx_q;
    dep_wdata_o = dep_dec;
    stk_we_o    = 1'b0;
    stk_waddr_o = {abs_idx_q, k_q - SUB_W'(1)};
    stk_wdata_o = k_q;
    fl_step     = 1'b0;
    fl_drop     = 1'b0;
    open_done   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.opcode)
            OP_ALLOC: begin
              idx_d     = LAST_IDX;
              abs_vld_d = 1'b0;
              state_d   = S_A_RD;
            end
            OP_RELEASE: begin
              if (rel_ok) begin
                idx_d   = SLOT_W'(super_f - FIELD_W'(1));
                b_d     = sub_f - SUBF_W'(1);
                state_d = S_R_RD;
              end else begin
                rsp_d        = '0;
                rsp_d.status = ST_REJECT;
                rsp_d.last   = 1'b1;
                ret_d        = S_IDLE;
                state_d      = S_OUT;
              end
            end
            default: begin
              idx_d      = '0;
              force_d    = (req_i.opcode == OP_FLUSH_ALL);
              pend_vld_d = 1'b0;
              state_d    = S_F_RD;
            end
          endcase
        end
      end

      // downward scan, absent slots skip the depth check
      S_A_RD: begin
        if (!present_q[idx_q]) begin
          abs_idx_d = idx_q;
          abs_vld_d = 1'b1;
          if (idx_q == '0) begin
            state_d = S_A_MISS;
          end else begin
            idx_d = idx_q - SLOT_W'(1);
          end
        end else begin
          state_d = S_A_CK;
        end
      end

      S_A_CK: begin
        if (dep_rdata_i != '0) begin
          // pop: lower the depth, top entry read this cycle
          dep_we_o = 1'b1;
          state_d  = S_A_POP;
        end else if (idx_q == '0) begin
          state_d = S_A_MISS;
        end else begin
          idx_d   = idx_q - SLOT_W'(1);
          state_d = S_A_RD;
        end
      end

      S_A_POP: begin
        rsp_d            = '0;
        rsp_d.status     = ST_OK;
        rsp_d.handle_out = {SUBF_W'(stk_rdata_i) + SUBF_W'(1),
                            FIELD_W'(idx_q) + FIELD_W'(1)};
        rsp_d.last       = 1'b1;
        ret_d            = S_IDLE;
        state_d          = S_OUT;
      end

      S_A_MISS: begin
        if (!abs_vld_q) begin
          rsp_d        = '0;
          rsp_d.status = ST_NO_FREE;
          rsp_d.last   = 1'b1;
          ret_d        = S_IDLE;
          state_d      = S_OUT;
        end else if (arity_m1 == '0) begin
          open_done = 1'b1;
        end else begin
          k_d     = SUB_W'(1);
          state_d = S_A_FILL;
        end
      end

      // one stack entry per cycle: entry k-1 holds k
      S_A_FILL: begin
        stk_we_o = 1'b1;
        if (DEPTH_W'(k_q) == arity_m1) begin
          open_done = 1'b1;
        end else begin
          k_d = k_q + SUB_W'(1);
        end
      end

      S_R_RD: begin
        state_d = S_R_CK;
      end

      S_R_CK: begin
        rsp_d      = '0;
        rsp_d.last = 1'b1;
        if (present_q[idx_q] && (b_q < SUBF_W'(arity_i)) && (dep_rdata_i < arity_i)) begin
          stk_we_o     = 1'b1;
          stk_waddr_o  = {idx_q, dep_rdata_i[SUB_W-1:0]};
          stk_wdata_o  = b_q[SUB_W-1:0];
          dep_we_o     = 1'b1;
          dep_wdata_o  = dep_inc;
          rsp_d.status = ST_OK;
        end else begin
          rsp_d.status = ST_REJECT;
        end
        ret_d   = S_IDLE;
        state_d = S_OUT;
      end

      // upward scan for flush
      S_F_RD: begin
        if (!present_q[idx_q]) begin
          fl_step = 1'b1;
        end else if (force_q) begin
          fl_drop = 1'b1;
        end else begin
          state_d = S_F_CK;
        end
      end

      S_F_CK: begin
        if (dep_rdata_i == arity_i) begin
          fl_drop = 1'b1;
        end else begin
          fl_step = 1'b1;
        end
      end

      S_F_END: begin
        rsp_d      = '0;
        rsp_d.last = 1'b1;
        if (pend_vld_q) begin
          rsp_d.dropped_slot  = DROP_W'(pend_idx_q);
          rsp_d.dropped_valid = 1'b1;
        end
        ret_d   = S_IDLE;
        state_d = S_OUT;
      end

      S_OUT: begin
        emit_o = can_emit_i;
        if (can_emit_i) begin
          state_d = ret_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // opening a slot: depth, present bit and the result
    if (open_done) begin
      dep_we_o               = 1'b1;
      dep_waddr_o            = abs_idx_q;
      dep_wdata_o            = arity_m1;
      present_d[abs_idx_q]   = 1'b1;
      rsp_d                  = '0;
      rsp_d.status           = ST_OK;
      rsp_d.handle_out       = {SUBF_W'(1), FIELD_W'(abs_idx_q) + FIELD_W'(1)};
      rsp_d.opened_new       = 1'b1;
      rsp_d.last             = 1'b1;
      ret_d                  = S_IDLE;
      state_d                = S_OUT;
    end

    // flush: a dropped slot is held back until the next drop or the end of the scan settles its last flag
    if (fl_step || fl_drop) begin
      if (idx_q != LAST_IDX) begin
        idx_d = idx_q + SLOT_W'(1);
      end
      state_d = fl_next;
    end
    if (fl_drop) begin
      present_d[idx_q] = 1'b0;
      pend_idx_d       = idx_q;
      pend_vld_d       = 1'b1;
      if (pend_vld_q) begin
        rsp_d               = '0;
        rsp_d.dropped_slot  = DROP_W'(pend_idx_q);
        rsp_d.dropped_valid = 1'b1;
        ret_d               = fl_next;
        state_d             = S_OUT;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      present_q  <= '0;
      abs_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      present_q  <= present_d;
      abs_vld_q  <= abs_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    abs_idx_q  <= abs_idx_d;
    pend_idx_q <= pend_idx_d;
    force_q    <= force_d;
    b_q        <= b_d;
    k_q        <= k_d;
    rsp_q      <= rsp_d;
  end

endmodule

>>> sv/two_level_tile_slot_allocator_unit.sv
// channel   | dir | handshake            | payload
// req_i     | in  | valid/ready transfer | opcode, handle_in
// rsp_o     | out | valid/ready transfer | status, handle_out, opened_new,
//           |     |                      | dropped_slot, dropped_valid, last
// cfg       | in  | cfg_we_i, no wait    | cfg_wdata_i (sub slots per super slot)
//
// one item at a time: a new request is taken only once the last one is done
// allocate: scans present slots downward and pops from the first with a free entry, else
//   opens the lowest absent slot and fills its stack, or reports that none is free
// release: checked against the stored state, or rejected on the handle fields alone; flush:
//   scans upward, one result per dropped slot; flush-empty drops only slots with all free
// reset clears the present bits but not the depth and stack stores, which hold garbage until a slot opens
// a stalled result stays in the output register; the sequencer waits for it to drain
module two_level_tile_slot_allocator_unit import tlsa_pkg::*; #(
  parameter int SUPER_SLOTS = SUPER_SLOTS_DEF,
  parameter int MAX_SUBS    = MAX_SUBS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tlsa_req_if.sink         req_i,
  tlsa_rsp_if.source       rsp_o
);

  localparam int SLOT_W  = (SUPER_SLOTS > 1) ? $clog2(SUPER_SLOTS) : 1;
  localparam int SUB_W   = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
  localparam int DEPTH_W = $clog2(MAX_SUBS + 1);

  logic [CFG_W-1:0]        arity_q;
  logic [DEPTH_W-1:0]      arity;
  logic                    can_emit, emit;
  rsp_t                    rsp;
  logic                    dep_we;
  logic [SLOT_W-1:0]       dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0]      dep_wdata, dep_rdata;
  logic                    stk_we;
  logic [SLOT_W+SUB_W-1:0] stk_waddr, stk_raddr;
  logic [SUB_W-1:0]        stk_wdata, stk_rdata;

  // arity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q <= ARITY_RST;
    end else if (cfg_we_i) begin
      arity_q <= cfg_wdata_i;
    end
  end

  // arity in use, clamped to 1..MAX_SUBS
  always_comb begin
    if (arity_q == '0) begin
      arity = DEPTH_W'(1);
    end else if (arity_q > CFG_W'(MAX_SUBS)) begin
      arity = DEPTH_W'(MAX_SUBS);
    end else begin
      arity = DEPTH_W'(arity_q);
    end
  end

  tlsa_ctrl #(
    .SUPER_SLOTS (SUPER_SLOTS),
    .MAX_SUBS    (MAX_SUBS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .arity_i     (arity),
    .can_emit_i  (can_emit),
    .emit_o      (emit),
    .rsp_o       (rsp),
    .dep_we_o    (dep_we),
    .dep_waddr_o (dep_waddr),
    .dep_wdata_o (dep_wdata),
    .dep_raddr_o (dep_raddr),
    .dep_rdata_i (dep_rdata),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata)
  );

  // free depth per super slot
  tlsa_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (SUPER_SLOTS)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  // free sub slot stacks, one row per super slot
  tlsa_ram #(
    .WIDTH (SUB_W),
    .DEPTH (SUPER_SLOTS * (1 << SUB_W))
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  tlsa_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (emit),
    .rsp_i      (rsp),
    .can_load_o (can_emit),
    .rsp_o      (rsp_o)
  );

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import tlsa_pkg::*;

  localparam int SUPER_SLOTS = SUPER_SLOTS_DEF;
  localparam int MAX_SUBS    = MAX_SUBS_DEF;
  localparam int N_PHASES    = 5;

  // one row of the directed stimulus
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic                typed;
    rsp_t                rsp;
  } stim_row_t;

  localparam rsp_t RSP_QUIET  = '{status: ST_OK, last: 1'b1, default: '0};
  localparam rsp_t RSP_REJECT = '{status: ST_REJECT, last: 1'b1, default: '0};
  localparam rsp_t RSP_OPEN0  = '{status: ST_OK, handle_out: 25'h001_0001, opened_new: 1'b1,
                                  last: 1'b1, default: '0};

  // directed rows, run at the reset arity of 64 with no slot present
  localparam stim_row_t DIRECTED [24] = '{
    '{OP_FLUSH_EMPTY, 25'h000_0000, 1'b1, RSP_QUIET},   // flush with nothing present
    '{OP_FLUSH_ALL,   25'h1FF_FFFF, 1'b1, RSP_QUIET},
    '{OP_RELEASE,     25'h000_0000, 1'b1, RSP_REJECT},  // zero handle
    '{OP_ALLOC,       25'h1FF_FFFF, 1'b1, RSP_OPEN0},   // opens slot 0, hands out sub 0
    '{OP_ALLOC,       25'h000_0000, 1'b0, '0},
    '{OP_ALLOC,       25'h155_5555, 1'b0, '0},
    '{OP_RELEASE,     25'h001_0001, 1'b1, RSP_QUIET},
    '{OP_RELEASE,     25'h040_0001, 1'b1, RSP_QUIET},
    '{OP_RELEASE,     25'h03F_0001, 1'b1, RSP_QUIET},   // stack now full
    '{OP_RELEASE,     25'h03F_0001, 1'b1, RSP_REJECT},  // push onto a full stack
    '{OP_RELEASE,     25'h001_0000, 1'b1, RSP_REJECT},  // super field zero
    '{OP_RELEASE,     25'h000_0001, 1'b1, RSP_REJECT},  // sub field zero
    '{OP_RELEASE,     25'h041_0001, 1'b1, RSP_REJECT},  // sub just past the arity
    '{OP_RELEASE,     25'h1FF_FFFF, 1'b1, RSP_REJECT},  // all ones
    '{OP_RELEASE,     25'h001_0041, 1'b1, RSP_REJECT},  // super past the last slot
    '{OP_RELEASE,     25'h001_0040, 1'b1, RSP_REJECT},  // last slot, absent
    '{OP_ALLOC,       25'h0AA_AAAA, 1'b0, '0},
    '{OP_FLUSH_EMPTY, 25'h000_0000, 1'b1, RSP_QUIET},   // slot 0 not empty
    '{OP_RELEASE,     25'h03F_0001, 1'b1, RSP_QUIET},
    '{OP_FLUSH_EMPTY, 25'h000_0000, 1'b0, '0},          // drops slot 0
    '{OP_ALLOC,       25'h000_0000, 1'b1, RSP_OPEN0},
    '{OP_ALLOC,       25'h000_0000, 1'b0, '0},
    '{OP_FLUSH_ALL,   25'h000_0000, 1'b0, '0},
    '{OP_RELEASE,     25'h001_0001, 1'b1, RSP_REJECT}   // slot gone
  };

  // random phases: arity, idling, length, opening burst, mix, flush first
  localparam int PH_ARITY   [N_PHASES] = '{256, 0, 3, 511, 1};
  localparam int PH_TX_IDLE [N_PHASES] = '{8, 8, 57, 57, 0};
  localparam int PH_RX_IDLE [N_PHASES] = '{57, 57, 8, 8, 0};
  localparam int PH_ITEMS   [N_PHASES] = '{32, 14, 32, 24, 24};
  localparam int PH_BURST   [N_PHASES] = '{0, 66, 0, 0, 0};
  localparam int PH_ALLOC   [N_PHASES] = '{50, 60, 45, 50, 55};
  localparam bit PH_FLUSH   [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  tlsa_req_if req_ch ();
  tlsa_rsp_if rsp_ch ();

  two_level_tile_slot_allocator_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // allocator image kept by the testbench
  logic [CFG_W-1:0] cfg_arity = ARITY_RST;
  bit               slot_live [SUPER_SLOTS];
  int unsigned      free_cnt  [SUPER_SLOTS];
  logic [7:0]       stack_img [SUPER_SLOTS][MAX_SUBS];

  rsp_t                item_rsps[$];
  rsp_t                expected_rsps[$];
  logic [HANDLE_W-1:0] held_handles[$];
  rsp_t                oldest;
  int                  mismatches = 0;
  int                  tx_idle_pct = 8;
  int                  rx_idle_pct = 57;

  always #5 clk_i = ~clk_i;

  // results of one request, computed from the allocator image
  function automatic void predict_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h);
    int unsigned ar, d, sub, sf, bf, s, b, k;
    int          i;
    bit          done;
    rsp_t        r;
    item_rsps.delete();
    ar = (cfg_arity == '0) ? 1 :
         ((32'(cfg_arity) > MAX_SUBS) ? MAX_SUBS : 32'(cfg_arity));
    r = '0;
    r.last = 1'b1;
    done = 1'b0;
    case (op)
      OP_ALLOC: begin
        // pop from the highest present slot with a free entry
        for (i = SUPER_SLOTS - 1; i >= 0; i--) begin
          if (slot_live[i] && free_cnt[i] > 0) begin
            d = free_cnt[i] - 1;
            if (d >= MAX_SUBS) d = MAX_SUBS - 1;
            sub = 32'(stack_img[i][d]);
            free_cnt[i] = d;
            r.handle_out = HANDLE_W'((i + 1) | ((sub + 1) << FIELD_W));
            done = 1'b1;
            break;
          end
        end
        // otherwise open the lowest absent slot
        if (!done) begin
          for (i = 0; i < SUPER_SLOTS; i++) begin
            if (!slot_live[i]) begin
              for (k = 1; k < ar; k++) stack_img[i][k-1] = 8'(k);
              free_cnt[i] = ar - 1;
              slot_live[i] = 1'b1;
              r.handle_out = HANDLE_W'((i + 1) | (1 << FIELD_W));
              r.opened_new = 1'b1;
              done = 1'b1;
              break;
            end
          end
        end
        if (!done) r.status = ST_NO_FREE;
        item_rsps.push_back(r);
      end
      OP_RELEASE: begin
        sf = 32'(h[FIELD_W-1:0]);
        bf = 32'(h[HANDLE_W-1:FIELD_W]);
        if (sf == 0 || sf - 1 >= SUPER_SLOTS || bf == 0) begin
          r.status = ST_REJECT;
        end else begin
          s = sf - 1;
          b = bf - 1;
          if (!slot_live[s] || b >= ar || free_cnt[s] >= ar) begin
            r.status = ST_REJECT;
          end else begin
            stack_img[s][free_cnt[s]] = 8'(b);
            free_cnt[s] = free_cnt[s] + 1;
          end
        end
        item_rsps.push_back(r);
      end
      default: begin
        // flush: one result per dropped slot, ascending
        for (i = 0; i < SUPER_SLOTS; i++) begin
          if (slot_live[i] && (op == OP_FLUSH_ALL || free_cnt[i] == ar)) begin
            slot_live[i] = 1'b0;
            r = '0;
            r.dropped_slot = i[DROP_W-1:0];
            r.dropped_valid = 1'b1;
            item_rsps.push_back(r);
          end
        end
        if (item_rsps.size() == 0) item_rsps.push_back(RSP_QUIET);
        else item_rsps[item_rsps.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // present one request, wait for its transfer, then record what it should produce
  task automatic put_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h, bit typed,
                          rsp_t typed_rsp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.handle_in <= h;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_item(op, h);
    if (typed) expected_rsps.push_back(typed_rsp);
    else foreach (item_rsps[j]) expected_rsps.push_back(item_rsps[j]);
    if (op == OP_ALLOC && item_rsps[0].status == ST_OK)
      held_handles.push_back(item_rsps[0].handle_out);
  endtask

  // random request; releases mostly return handles that are out
  task automatic random_item(int alloc_pct);
    int                  roll, k, idx;
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(99);
    h = HANDLE_W'($urandom);
    if (roll < alloc_pct) begin
      op = OP_ALLOC;
    end else if (roll < alloc_pct + (100 - alloc_pct) * 7 / 10) begin
      op = OP_RELEASE;
      k = $urandom_range(9);
      if (held_handles.size() != 0 && k < 7) begin
        idx = $urandom_range(held_handles.size() - 1);
        h = held_handles[idx];
        // keep it now and then so it gets released twice
        if (k < 6) held_handles.delete(idx);
      end else if (k == 7) begin
        h = {SUBF_W'($urandom_range(258)), FIELD_W'($urandom_range(66))};
      end
    end else if (roll < 97) begin
      op = OP_FLUSH_EMPTY;
    end else begin
      op = OP_FLUSH_ALL;
    end
    put_item(op, h, 1'b0, '0);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic settle(int pad);
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_arity(logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_arity = v;
  endtask

  // receiver stalls at random
  always @(posedge clk_i) rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("result with nothing expected: status %0d handle 0x%0h",
               rsp_ch.status, rsp_ch.handle_out);
        mismatches++;
      end else begin
        oldest = expected_rsps.pop_front();
        check_field("status", 32'(oldest.status), 32'(rsp_ch.status));
        check_field("handle_out", 32'(oldest.handle_out), 32'(rsp_ch.handle_out));
        check_field("opened_new", 32'(oldest.opened_new), 32'(rsp_ch.opened_new));
        check_field("dropped_slot", 32'(oldest.dropped_slot), 32'(rsp_ch.dropped_slot));
        check_field("dropped_valid", 32'(oldest.dropped_valid), 32'(rsp_ch.dropped_valid));
        check_field("last", 32'(oldest.last), 32'(rsp_ch.last));
      end
    end
  end

  initial begin
    int p, n;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_ALLOC;
    req_ch.handle_in = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      put_item(DIRECTED[i].op, DIRECTED[i].handle, DIRECTED[i].typed, DIRECTED[i].rsp);

    for (p = 0; p < N_PHASES; p++) begin
      if (PH_FLUSH[p]) begin
        put_item(OP_FLUSH_ALL, HANDLE_W'($urandom), 1'b0, '0);
        held_handles.delete();
      end
      settle(20);
      write_arity(CFG_W'(PH_ARITY[p]));
      tx_idle_pct = PH_TX_IDLE[p];
      rx_idle_pct = PH_RX_IDLE[p];
      // run of allocations that fills every slot, in a phase that has a burst
      for (n = 0; n < PH_BURST[p]; n++) put_item(OP_ALLOC, HANDLE_W'($urandom), 1'b0, '0);
      for (n = 0; n < PH_ITEMS[p]; n++) begin
        if (n == PH_ITEMS[p] / 2) settle(0);
        random_item(PH_ALLOC[p]);
      end
    end

    settle(40);
    if (mismatches == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> files.f
sv/tlsa_pkg.sv
sv/tlsa_req_if.sv
sv/tlsa_rsp_if.sv
sv/tlsa_ram.sv
sv/tlsa_out_reg.sv
sv/tlsa_ctrl.sv
sv/two_level_tile_slot_allocator_unit.sv
tb/sv/tb_top.sv
